FILE: design/cbts_pkg.sv
// Package for the CAN bit timing search: search limits, derived widths,
// controller states and the command and status structs. No dependencies.
`default_nettype none

package cbts_pkg;

    localparam int DIV_MAX    = 15;
    localparam int QUANTA_MAX = 32;
    localparam int SEGS_MAX   = 17;
    localparam int SEGS_MIN   = 3;
    localparam int SJW_LIMIT  = 3;

    localparam int CLK_W   = 32;
    localparam int BAUD_W  = 20;
    localparam int PDIV_W  = 4;
    localparam int TWORD_W = 15;
    localparam logic [CLK_W-1:0] RESET_CLOCK_HZ = 32'd48000000;

    localparam int DIV_W   = $clog2(DIV_MAX + 1);
    localparam int Q_W     = $clog2(QUANTA_MAX + 1);
    localparam int S_W     = $clog2(SEGS_MAX + 1);
    localparam int STEP_W  = $clog2(QUANTA_MAX * (DIV_MAX + 1) + 1);
    localparam int PROD_W  = $clog2(SEGS_MAX * QUANTA_MAX * (DIV_MAX + 1) + 1);
    localparam int DCNT_W  = $clog2(CLK_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic search_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic baud_zero;
        logic div_done;
        logic match;
        logic search_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: design/cbts_dp.sv
// Datapath of the CAN bit timing search: configuration register, restoring
// divider, incremental candidate search and result registers. Uses cbts_pkg.
`default_nettype none

module cbts_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_write,
    input  wire logic [cbts_pkg::CLK_W-1:0]       i_cfg_data,
    input  wire logic [cbts_pkg::BAUD_W-1:0]      i_baud_rate,
    input  wire cbts_pkg::t_dp_cmd                i_cmd,
    output cbts_pkg::t_dp_stat                    o_stat,
    output logic                                  o_found,
    output logic [cbts_pkg::PDIV_W-1:0]           o_prescaler_div,
    output logic [cbts_pkg::TWORD_W-1:0]          o_timing_word
);

    logic [cbts_pkg::CLK_W-1:0]  r_clock_hz;
    logic [cbts_pkg::BAUD_W-1:0] r_baud;
    logic [cbts_pkg::BAUD_W-1:0] r_rem;
    logic [cbts_pkg::CLK_W-1:0]  r_quo;
    logic [cbts_pkg::DCNT_W-1:0] r_dcnt;
    logic [cbts_pkg::DIV_W-1:0]  r_div;
    logic [cbts_pkg::Q_W-1:0]    r_quanta;
    logic [cbts_pkg::S_W-1:0]    r_segs;
    logic [cbts_pkg::STEP_W-1:0] r_step;
    logic [cbts_pkg::PROD_W-1:0] r_prod;
    logic                        r_found;
    logic [cbts_pkg::PDIV_W-1:0] r_pdiv;
    logic [cbts_pkg::TWORD_W-1:0] r_tword;

    logic [cbts_pkg::BAUD_W:0]   rem_sh;
    logic [cbts_pkg::BAUD_W:0]   rem_diff;
    logic                        q_bit;
    logic                        seg_last;
    logic                        quanta_last;
    logic                        div_last;
    logic [cbts_pkg::STEP_W-1:0] n_step;
    logic [cbts_pkg::PROD_W-1:0] n_prod3;
    logic [31:0]                 s_val;
    logic [31:0]                 seg1;
    logic [31:0]                 seg2;
    logic [31:0]                 sjw;
    logic [31:0]                 qm1;
    logic [31:0]                 div_ext;
    logic [cbts_pkg::TWORD_W-1:0] tword;

    assign rem_sh   = {r_rem, r_quo[cbts_pkg::CLK_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_baud};
    assign q_bit    = ~rem_diff[cbts_pkg::BAUD_W];

    assign seg_last    = (r_segs == cbts_pkg::S_W'(cbts_pkg::SEGS_MAX));
    assign quanta_last = (r_quanta == cbts_pkg::Q_W'(cbts_pkg::QUANTA_MAX));
    assign div_last    = (r_div == cbts_pkg::DIV_W'(cbts_pkg::DIV_MAX));

    always_comb begin
        if (quanta_last) begin
            n_step = cbts_pkg::STEP_W'(r_div) + cbts_pkg::STEP_W'(2);
        end else begin
            n_step = r_step + cbts_pkg::STEP_W'(r_div) + cbts_pkg::STEP_W'(1);
        end
        n_prod3 = cbts_pkg::PROD_W'(n_step) + (cbts_pkg::PROD_W'(n_step) << 1);
    end

    always_comb begin
        s_val   = 32'(r_segs) - 32'(cbts_pkg::SEGS_MIN);
        seg1    = s_val >> 1;
        seg2    = s_val - seg1;
        sjw     = (seg1 > 32'(cbts_pkg::SJW_LIMIT)) ? 32'(cbts_pkg::SJW_LIMIT) : seg1;
        qm1     = 32'(r_quanta) - 32'd1;
        div_ext = 32'(r_div);
        tword   = {seg2[2:0], seg1[3:0], sjw[1:0], qm1[5:0]};
    end

    assign o_stat.baud_zero   = (i_baud_rate == '0);
    assign o_stat.div_done    = (r_dcnt == cbts_pkg::DCNT_W'(cbts_pkg::CLK_W));
    assign o_stat.match       = ({{(cbts_pkg::CLK_W-cbts_pkg::PROD_W){1'b0}}, r_prod} == r_quo);
    assign o_stat.search_last = seg_last && quanta_last && div_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= cbts_pkg::RESET_CLOCK_HZ;
        end else if (i_cfg_write) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_baud   <= i_baud_rate;
            r_rem    <= '0;
            r_quo    <= (i_baud_rate == '0) ? '0 : r_clock_hz;
            r_dcnt   <= '0;
            r_div    <= '0;
            r_quanta <= cbts_pkg::Q_W'(1);
            r_segs   <= cbts_pkg::S_W'(cbts_pkg::SEGS_MIN);
            r_step   <= cbts_pkg::STEP_W'(1);
            r_prod   <= cbts_pkg::PROD_W'(cbts_pkg::SEGS_MIN);
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? rem_diff[cbts_pkg::BAUD_W-1:0] : rem_sh[cbts_pkg::BAUD_W-1:0];
            r_quo  <= {r_quo[cbts_pkg::CLK_W-2:0], q_bit};
            r_dcnt <= r_dcnt + cbts_pkg::DCNT_W'(1);
        end else if (i_cmd.search_step) begin
            if (!seg_last) begin
                r_segs <= r_segs + cbts_pkg::S_W'(1);
                r_prod <= r_prod + cbts_pkg::PROD_W'(r_step);
            end else begin
                r_segs <= cbts_pkg::S_W'(cbts_pkg::SEGS_MIN);
                r_step <= n_step;
                r_prod <= n_prod3;
                if (!quanta_last) begin
                    r_quanta <= r_quanta + cbts_pkg::Q_W'(1);
                end else begin
                    r_quanta <= cbts_pkg::Q_W'(1);
                    r_div    <= r_div + cbts_pkg::DIV_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found <= o_stat.match;
            r_pdiv  <= o_stat.match ? div_ext[cbts_pkg::PDIV_W-1:0] : '0;
            r_tword <= o_stat.match ? tword : '0;
        end
    end

    assign o_found         = r_found;
    assign o_prescaler_div = r_pdiv;
    assign o_timing_word   = r_tword;

endmodule

`default_nettype wire

FILE: design/cbts_ctrl.sv
// Controller of the CAN bit timing search: sequences load, divide, search and
// result hand-off, and owns both channel handshakes. Uses cbts_pkg.
`default_nettype none

module cbts_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire cbts_pkg::t_dp_stat i_stat,
    output cbts_pkg::t_dp_cmd       o_cmd
);

    cbts_pkg::t_state r_state;
    cbts_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            cbts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.baud_zero ? cbts_pkg::ST_EMIT : cbts_pkg::ST_DIVIDE;
                end
            end
            cbts_pkg::ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    n_state = cbts_pkg::ST_SEARCH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            cbts_pkg::ST_SEARCH: begin
                if (i_stat.match || i_stat.search_last) begin
                    n_state = cbts_pkg::ST_EMIT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            cbts_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = cbts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbts_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != cbts_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: design/can_bit_timing_search.sv
// Top level of the CAN bit timing search: joins the controller and the
// datapath. Uses cbts_pkg, cbts_ctrl and cbts_dp.
//
//   channel  direction  handshake                 beat
//   in       input      i_in_valid / o_in_stall   i_baud_rate
//   out      output     o_out_valid / i_out_stall o_found, o_prescaler_div, o_timing_word
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (peripheral clock in Hz)
//
// One beat is taken at a time. A request passes a load step, the bit-serial
// divider and the search, which visits one candidate per cycle (at most
// 16 * 32 * 15 = 7680 candidates), then the result moves into the output register.
// A zero baud rate skips the divider and the search. Reset restores the clock
// register to 48 MHz and clears o_out_valid. A stalled result blocks only the hand-off.
`default_nettype none

module can_bit_timing_search (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cbts_pkg::CLK_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [cbts_pkg::BAUD_W-1:0]     i_baud_rate,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_found,
    output logic [cbts_pkg::PDIV_W-1:0]          o_prescaler_div,
    output logic [cbts_pkg::TWORD_W-1:0]         o_timing_word
);

    cbts_pkg::t_dp_cmd  cmd;
    cbts_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    cbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cbts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_baud_rate     (i_baud_rate),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_found         (o_found),
        .o_prescaler_div (o_prescaler_div),
        .o_timing_word   (o_timing_word)
    );

endmodule

`default_nettype wire
